// ===== hdl/assert_macros.svh =====
// Assertion macros used by the scanner checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// antecedent this cycle implies consequent next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ssrs_pkg.sv =====
// Types, constants and tables of the seven-segment rotating scanner
package ssrs_pkg;

	localparam int DIGIT_COUNT = 4;
	localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam logic [15:0] RESET_PERIOD = 16'd1000;
	localparam logic [3:0] DIGIT_LIMIT = 4'd10;

	typedef logic [3:0] digit_t;
	typedef logic [POS_W-1:0] pos_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_SET  = 1'b1
	} op_t;

	// per-cell control from the scanner to the digit chain
	typedef struct packed {
		logic   shift;
		logic   write;
		digit_t data;
	} cell_ctrl_t;

	function automatic digit_t reset_digit(input int p);
		return digit_t'((p + 1) % 10);
	endfunction

	function automatic logic [7:0] seg_code(input digit_t v);
		logic [7:0] code;
		unique case (v)
			4'd0: code = 8'h03;
			4'd1: code = 8'h9f;
			4'd2: code = 8'h25;
			4'd3: code = 8'h0d;
			4'd4: code = 8'h99;
			4'd5: code = 8'h49;
			4'd6: code = 8'h41;
			4'd7: code = 8'h1f;
			4'd8: code = 8'h01;
			4'd9: code = 8'h09;
			default: code = 8'hff;
		endcase
		return code;
	endfunction

	function automatic logic [7:0] enable_code(input logic [2:0] p);
		logic [7:0] code;
		unique case (p)
			3'd0: code = 8'hbf;
			3'd1: code = 8'hdf;
			3'd2: code = 8'hef;
			3'd3: code = 8'h7f;
			3'd4: code = 8'hfe;
			3'd5: code = 8'hfd;
			3'd6: code = 8'hfb;
			default: code = 8'hf7;
		endcase
		return code;
	endfunction

endpackage

// ===== hdl/seven_segment_rotating_scanner_unit.sv =====
// Top level: scan position, countdown, digit chain and output register
//
//  channel | direction | handshake             | payload
//  in      | to block  | in_valid / in_ready   | operation, digit_index, digit_value
//  out     | from block| out_valid / out_ready | segment_code, digit_enable, rotated
//  cfg     | to block  | cfg_wr_en             | cfg_wr_data (tick_period)
//
// One word a cycle while in_ready is high; a tick word shows its frame on the output the next cycle.
// The single output register sets the pace: in_ready drops only while a frame waits
// and out_ready is low. Set-digit words produce nothing.
// Reset loads digits 1,2,3,4, scan position 0, period and countdown 1000.
module seven_segment_rotating_scanner_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [2:0]  digit_index,
	input  logic [3:0]  digit_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  segment_code,
	output logic [7:0]  digit_enable,
	output logic        rotated,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	localparam int N = ssrs_pkg::DIGIT_COUNT;

	logic [15:0] period_q;
	logic [15:0] count_q;
	ssrs_pkg::pos_t pos_q;
	logic out_valid_q;
	logic [7:0] seg_q;
	logic [7:0] en_q;
	logic rot_q;

	logic in_acc;
	logic tick;
	logic set_ok;
	logic expired;
	ssrs_pkg::digit_t digit_w [N];
	ssrs_pkg::cell_ctrl_t ctrl_w [N];

	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;
	assign tick     = in_acc && (ssrs_pkg::op_t'(operation) == ssrs_pkg::OP_TICK);
	assign set_ok   = in_acc && (ssrs_pkg::op_t'(operation) == ssrs_pkg::OP_SET)
		&& ({1'b0, digit_index} < 4'(N)) && (digit_value < ssrs_pkg::DIGIT_LIMIT);
	assign expired  = tick && (count_q == 16'd1);

	// digit chain: rotate right, last cell feeds the first
	for (genvar i = 0; i < N; i++) begin : g_cell
		always_comb begin
			ctrl_w[i].shift = expired;
			ctrl_w[i].write = set_ok && (digit_index == 3'(i));
			ctrl_w[i].data  = digit_value;
		end

		ssrs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.rst_value(ssrs_pkg::reset_digit(i)),
			.ctrl     (ctrl_w[i]),
			.shift_in (digit_w[(i + N - 1) % N]),
			.value_q  (digit_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= ssrs_pkg::RESET_PERIOD;
			count_q  <= ssrs_pkg::RESET_PERIOD;
			pos_q    <= '0;
		end else if (cfg_wr_en) begin
			period_q <= cfg_wr_data;
			count_q  <= cfg_wr_data;
		end else if (tick) begin
			if (expired) begin
				count_q <= period_q;
			end else if (count_q != 16'd0) begin
				count_q <= count_q - 16'd1;
			end
			if (pos_q == ssrs_pkg::pos_t'(N - 1)) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + ssrs_pkg::pos_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			seg_q <= ssrs_pkg::seg_code(digit_w[pos_q]);
			en_q  <= ssrs_pkg::enable_code(3'(pos_q));
			rot_q <= expired;
		end
	end

	assign out_valid    = out_valid_q;
	assign segment_code = seg_q;
	assign digit_enable = en_q;
	assign rotated      = rot_q;

endmodule

// ===== hdl/ssrs_cell.sv =====
// One digit cell of the rotating chain
module ssrs_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  ssrs_pkg::digit_t    rst_value,
	input  ssrs_pkg::cell_ctrl_t ctrl,
	input  ssrs_pkg::digit_t    shift_in,
	output ssrs_pkg::digit_t    value_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= rst_value;
		end else if (ctrl.shift) begin
			value_q <= shift_in;
		end else if (ctrl.write) begin
			value_q <= ctrl.data;
		end
	end

endmodule

// ===== hdl/ssrs_checker.sv =====
// Port-level checks of the scanner, bound to the top level
`include "assert_macros.svh"

module ssrs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        operation,
	input logic [2:0]  digit_index,
	input logic [3:0]  digit_value,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  segment_code,
	input logic [7:0]  digit_enable,
	input logic        rotated,
	input logic        cfg_wr_en,
	input logic [15:0] cfg_wr_data
);

	// stalled frame holds
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(segment_code) && $stable(digit_enable) && $stable(rotated), "stalled frame changed")

	// every accepted tick word shows a frame next cycle
	`ASSERT_NEXT(a_tick_frame, in_valid && in_ready && (operation == 1'b0), out_valid, "tick word gave no frame")

	// set-digit words never make a frame appear
	`ASSERT_NEXT(a_set_quiet, in_valid && in_ready && (operation == 1'b1) && (!out_valid || out_ready), !out_valid, "set-digit word gave a frame")

	// exactly one position is enabled in a shown frame
	`ASSERT_ALWAYS(a_one_enable, !out_valid || ($countones(~digit_enable) == 1), "enable not one-hot-low")

endmodule

bind seven_segment_rotating_scanner_unit ssrs_checker u_ssrs_checker (.*);
